// File: rtl/html_entity_escaper_top_macros.svh
// Assertion helpers, clocked on clk, disabled in reset.
`ifndef HTML_ENTITY_ESCAPER_TOP_MACROS_SVH
`define HTML_ENTITY_ESCAPER_TOP_MACROS_SVH

// Same-cycle implication.
`define HEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hee_pkg.sv
package hee_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam logic [15:0] CAP_RESET = 16'd256;

  typedef enum logic [2:0] {
    CODE_NONE,
    CODE_PLAIN,
    CODE_LT,
    CODE_GT,
    CODE_AMP,
    CODE_QUOT,
    CODE_APOS
  } code_t;

  typedef struct packed {
    code_t       code;
    logic [7:0]  data;
    logic        term;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic code_t classify(input logic [7:0] b);
    code_t c;
    case (b)
      "<":     c = CODE_LT;
      ">":     c = CODE_GT;
      "&":     c = CODE_AMP;
      "\"":    c = CODE_QUOT;
      "'":     c = CODE_APOS;
      default: c = CODE_PLAIN;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] ent_len(input code_t c);
    logic [2:0] n;
    case (c)
      CODE_PLAIN: n = 3'd1;
      CODE_LT:    n = 3'd4;
      CODE_GT:    n = 3'd4;
      CODE_AMP:   n = 3'd5;
      CODE_QUOT:  n = 3'd6;
      CODE_APOS:  n = 3'd5;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] ent_char(input code_t c, input logic [2:0] idx,
                                          input logic [7:0] data);
    logic [7:0] ch;
    ch = "&";
    if (idx != 3'd0) begin
      case (c)
        CODE_LT: begin
          case (idx)
            3'd1:    ch = "l";
            3'd2:    ch = "t";
            default: ch = ";";
          endcase
        end
        CODE_GT: begin
          case (idx)
            3'd1:    ch = "g";
            3'd2:    ch = "t";
            default: ch = ";";
          endcase
        end
        CODE_AMP: begin
          case (idx)
            3'd1:    ch = "a";
            3'd2:    ch = "m";
            3'd3:    ch = "p";
            default: ch = ";";
          endcase
        end
        CODE_QUOT: begin
          case (idx)
            3'd1:    ch = "q";
            3'd2:    ch = "u";
            3'd3:    ch = "o";
            3'd4:    ch = "t";
            default: ch = ";";
          endcase
        end
        CODE_APOS: begin
          case (idx)
            3'd1:    ch = "#";
            3'd2:    ch = "3";
            3'd3:    ch = "9";
            default: ch = ";";
          endcase
        end
        default: ch = data;
      endcase
    end else if (c == CODE_PLAIN) begin
      ch = data;
    end
    return ch;
  endfunction

endpackage

// File: rtl/hee_front.sv
module hee_front
  import hee_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_of_string,
  input  logic [15:0] cap,
  input  q_stat_t     q_stat,
  output logic        q_push,
  output job_t        q_job
);

  logic [15:0] count_r, count_nxt;
  logic        stop_r, stop_nxt;
  logic        accept, active, emit, fits;
  code_t       code;
  logic [2:0]  n;
  logic [16:0] sum;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign code     = classify(in_byte);
  assign n        = ent_len(code);
  assign sum      = {1'b0, count_r} + {14'd0, n};
  assign fits     = sum < {1'b0, cap};
  assign active   = (cap != 16'd0) && !stop_r;
  assign emit     = active && (in_byte != 8'd0) && fits;

  always_comb begin
    count_nxt = count_r;
    stop_nxt  = stop_r;
    if (accept) begin
      if (emit) count_nxt = sum[15:0];
      else if (active) stop_nxt = 1'b1;
      if (in_last_of_string) begin
        count_nxt = 16'd0;
        stop_nxt  = 1'b0;
      end
    end
  end

  assign q_push     = accept && (emit || (in_last_of_string && cap != 16'd0));
  assign q_job.code = emit ? code : CODE_NONE;
  assign q_job.data = in_byte;
  assign q_job.term = in_last_of_string;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 16'd0;
      stop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

// File: rtl/hee_queue.sv
module hee_queue
  import hee_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == (QAW+1)'(QDEPTH);
  assign stat.empty = cnt_r == '0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/hee_back.sv
module hee_back
  import hee_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_terminator,
  output logic       out_last_of_run
);

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_term_r, out_last_r;
  logic       adv, take, is_term, is_last;
  logic [2:0] len, total;

  assign len     = ent_len(head.code);
  assign total   = len + {2'd0, head.term};
  assign is_term = idx_r == len;
  assign is_last = idx_r == (total - 3'd1);
  assign adv     = !out_valid_r || out_ready;
  assign take    = adv && !q_stat.empty;
  assign pop     = take && is_last;
  assign idx_nxt = take ? (is_last ? 3'd0 : idx_r + 3'd1) : idx_r;

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r <= is_term ? 8'd0 : ent_char(head.code, idx_r, head.data);
      out_term_r <= is_term;
      out_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (adv) out_valid_r <= !q_stat.empty;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_is_terminator = out_term_r;
  assign out_last_of_run   = out_last_r;

endmodule

// File: rtl/html_entity_escaper_top.sv
// channel  dir  handshake             payload
// in       in   in_valid/in_ready     in_byte[7:0], in_last_of_string
// out      out  out_valid/out_ready   out_byte[7:0], out_is_terminator, out_last_of_run
// cfg      in   cfg_valid/cfg_ready   cfg_data[15:0] (output capacity)
//
// Plain bytes: one transfer per cycle in and out while neither side stalls, via the
// queue and the output register. An entity gives 4 to 6 output bytes, one more with
// the terminator (back end's byte counter); input stalls once the 2-deep queue fills.
// Reset clears count, stop flag, queue and output; capacity resets to 256.
// Either side may stall independently; cfg_ready is always high.
`include "html_entity_escaper_top_macros.svh"

module html_entity_escaper_top
  import hee_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_terminator,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] cap_r;
  logic        q_push, q_pop;
  job_t        q_job, q_head;
  q_stat_t     q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  hee_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_last_of_string (in_last_of_string),
    .cap               (cap_r),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_job             (q_job)
  );

  hee_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  hee_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .q_stat            (q_stat),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_is_terminator (out_is_terminator),
    .out_last_of_run   (out_last_of_run)
  );

  `HEE_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "push into full queue")
  `HEE_ASSERT_NOW(a_zero_cap_silent, cap_r == 16'd0, !q_push, "job queued at zero capacity")
  `HEE_ASSERT_NOW(a_term_ends_run, out_valid && out_is_terminator,
                  out_last_of_run && out_byte == 8'd0, "terminator not closing run")
  `HEE_ASSERT_NEXT(a_pop_nonempty, q_pop, out_valid, "pop without a result")

endmodule

// File: verif/tb_html_entity_escaper_top.sv
`timescale 1ns / 1ps

module tb_html_entity_escaper_top;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 135;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic       run_end;
  } esc_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last_of_string;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_is_terminator;
  logic        out_last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // escaper shadow state
  logic [15:0] cap_reg;
  logic [15:0] byte_count;
  logic        copy_halt;

  esc_byte_t   pending_bytes[$];
  int          err_count;
  int          stall_cycles;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int          rx_hold;
  int          rx_next;

  html_entity_escaper_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_last_of_string (in_last_of_string),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_is_terminator (out_is_terminator),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic escape_byte(input logic [7:0] b, input logic l);
    esc_byte_t run[7];
    string     ent;
    int        n;
    int        k;
    k = 0;
    if (cap_reg != 16'd0 && !copy_halt) begin
      if (b == 8'h00) begin
        copy_halt = 1'b1;
      end else begin
        case (b)
          "<":     ent = "&lt;";
          ">":     ent = "&gt;";
          "&":     ent = "&amp;";
          "\"":    ent = "&quot;";
          "'":     ent = "&#39;";
          default: ent = "";
        endcase
        n = (ent.len() == 0) ? 1 : ent.len();
        if (int'(byte_count) + n < int'(cap_reg)) begin
          for (int i = 0; i < n; i++) begin
            run[k] = '{(ent.len() == 0) ? b : ent[i], 1'b0, 1'b0};
            k++;
          end
          byte_count = byte_count + 16'(n);
        end else begin
          copy_halt = 1'b1;
        end
      end
    end
    if (l) begin
      if (cap_reg != 16'd0) begin
        run[k] = '{8'h00, 1'b1, 1'b0};
        k++;
      end
      byte_count = 16'd0;
      copy_halt  = 1'b0;
    end
    if (k > 0) run[k-1].run_end = 1'b1;
    for (int i = 0; i < k; i++) pending_bytes.push_back(run[i]);
  endtask

  task automatic check_result(input esc_byte_t got);
    esc_byte_t want;
    if (pending_bytes.size() == 0) begin
      note_error($sformatf("unexpected result byte=%02h term=%0b end=%0b",
                           got.data, got.term, got.run_end));
    end else begin
      want = pending_bytes.pop_front();
      if (got.data !== want.data)
        note_error($sformatf("out_byte exp %02h got %02h", want.data, got.data));
      if (got.term !== want.term)
        note_error($sformatf("out_is_terminator exp %0b got %0b", want.term, got.term));
      if (got.run_end !== want.run_end)
        note_error($sformatf("out_last_of_run exp %0b got %0b (byte %02h)",
                             want.run_end, got.run_end, want.data));
    end
  endtask

  // transfer monitor: predicts on input, checks on output
  always @(posedge clk) begin
    if (!rst_n) begin
      cap_reg      = hee_pkg::CAP_RESET;
      byte_count   = 16'd0;
      copy_halt    = 1'b0;
      stall_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (in_valid && in_ready) escape_byte(in_byte, in_last_of_string);
      if (out_valid && out_ready)
        check_result('{out_byte, out_is_terminator, out_last_of_run});
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // sink backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold   <= 0;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_next = rx_idle_en ? $urandom_range(0, 13) : 0;
      rx_hold   <= rx_next;
      out_ready <= (rx_next == 0);
    end else if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_byte           <= b;
    in_last_of_string <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 19);
    if (r < 10) begin
      b = 8'($urandom_range(32, 126));
    end else if (r < 15) begin
      case ($urandom_range(0, 4))
        0:       b = "<";
        1:       b = ">";
        2:       b = "&";
        3:       b = "\"";
        default: b = "'";
      endcase
    end else if (r == 15) begin
      b = 8'h00;
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  function automatic logic [15:0] pick_capacity();
    logic [15:0] c;
    case ($urandom_range(0, 5))
      0:       c = 16'd0;
      1:       c = 16'hFFFF;
      2:       c = 16'($urandom_range(1, 8));
      3:       c = 16'($urandom_range(9, 40));
      4:       c = 16'($urandom_range(41, 300));
      default: c = 16'($urandom_range(0, 65535));
    endcase
    return c;
  endfunction

  // all five entities plus plain extremes, reset capacity
  task automatic test_entities();
    send_item("A", 1'b0);
    send_item("<", 1'b0);
    send_item(">", 1'b0);
    send_item("&", 1'b0);
    send_item("\"", 1'b0);
    send_item("'", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h01, 1'b1);
    wait_drained();
  endtask

  task automatic test_zero_byte();
    send_item("x", 1'b0);
    send_item(8'h00, 1'b0);
    send_item("y", 1'b0);
    send_item("z", 1'b1);
    send_item(8'h00, 1'b1);
    wait_drained();
  endtask

  // entity that does not fit, exact fit, capacity of one
  task automatic test_tight_capacity();
    write_capacity(16'd6);
    send_item("\"", 1'b0);
    send_item("a", 1'b1);
    wait_drained();
    write_capacity(16'd7);
    send_item("\"", 1'b0);
    send_item("c", 1'b1);
    wait_drained();
    write_capacity(16'd1);
    send_item("a", 1'b1);
    wait_drained();
  endtask

  task automatic test_zero_capacity();
    write_capacity(16'd0);
    send_item("a", 1'b0);
    send_item("<", 1'b0);
    send_item("b", 1'b1);
    wait_drained();
    write_capacity(16'hFFFF);
    send_item("&", 1'b1);
    wait_drained();
  endtask

  // capacity dropped to the running count mid-string
  task automatic test_capacity_lowered();
    write_capacity(16'd100);
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item("c", 1'b0);
    wait_drained();
    write_capacity(16'd3);
    send_item("d", 1'b0);
    send_item("e", 1'b1);
    wait_drained();
  endtask

  task automatic test_random_text();
    int sent;
    int str_left;
    int phase_left;
    sent       = 0;
    str_left   = 0;
    phase_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        wait_drained();
        write_capacity(pick_capacity());
        rx_idle_en = ($urandom_range(0, 3) != 0);
        phase_left = $urandom_range(10, 30);
      end
      if (str_left == 0) begin
        str_left   = $urandom_range(1, 12);
        tx_idle_en = ($urandom_range(0, 3) != 0);
      end
      str_left--;
      phase_left--;
      send_item(pick_text_byte(), str_left == 0);
      sent++;
    end
    wait_drained();
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_byte           <= 8'h00;
    in_last_of_string <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_data          <= 16'd0;
    err_count  = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_entities();
    test_zero_byte();
    test_tight_capacity();
    test_zero_capacity();
    test_capacity_lowered();
    test_random_text();

    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    @(posedge clk);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
